[rtl/assert_macros.svh]
// ---------------------------------------------------------------------------
// Assertion macros
// Clocked property checks with an active-low reset disable.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_CLK(name, prop, clk, rst_n) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");

`define ASSERT_NEVER(name, expr, clk, rst_n) \
  name: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error("forbidden condition seen");

`else

`define ASSERT_CLK(name, prop, clk, rst_n)

`define ASSERT_NEVER(name, expr, clk, rst_n)

`endif

`endif

[rtl/nalps_pkg.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// NAL parameter-set run finder package
// Codec codes, NAL type codes and default sizes.
// ---------------------------------------------------------------------------
package nalps_pkg;

  localparam int unsigned PositionBitsDflt = 24;
  localparam int unsigned OffsetBits       = 24;
  localparam int unsigned ByteBits         = 8;
  localparam int unsigned CodecBits        = 2;

  localparam logic [CodecBits-1:0] CodecH264 = 2'd0;
  localparam logic [CodecBits-1:0] CodecH265 = 2'd1;

  // H.264 nal_unit_type (5 bits)
  localparam logic [4:0] H264Sps = 5'd7;
  localparam logic [4:0] H264Pps = 5'd8;
  localparam logic [4:0] H264Aud = 5'd9;

  // H.265 nal_unit_type (6 bits)
  localparam logic [5:0] H265Vps = 6'd32;
  localparam logic [5:0] H265Sps = 6'd33;
  localparam logic [5:0] H265Pps = 6'd34;
  localparam logic [5:0] H265Aud = 6'd35;

  localparam logic [1:0] ZeroRunMax = 2'd3;

endpackage

[rtl/nal_parameter_set_run_finder_unit.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// NAL parameter-set run finder
// Scans Annex-B access unit bytes for start codes, classifies NAL headers
// and reports where the leading run of parameter-set NALs ends.
// ---------------------------------------------------------------------------
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+------------------------------
//  in      | input     | in_valid_i/in_ready_o  | stream_byte_i, end_of_unit_i
//  out     | output    | out_valid_o/out_ready_i| run_end_offset_o, sps_present_o
//  cfg     | input     | cfg_we_i               | cfg_wdata_i (codec kind)
//
// One byte per cycle: input register, one level of scan logic, result
// register. A result is registered as the final byte leaves the input register.
// Only the final byte of a unit waits on the result register; other bytes
// pass even while a result is stalled.
// Reset clears the scan state and selects H.264 headers.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module nal_parameter_set_run_finder_unit #(
  parameter int unsigned PositionBits = nalps_pkg::PositionBitsDflt
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [nalps_pkg::CodecBits-1:0]      cfg_wdata_i,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic [nalps_pkg::ByteBits-1:0]       stream_byte_i,
  input  logic                                 end_of_unit_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic [nalps_pkg::OffsetBits-1:0]     run_end_offset_o,
  output logic                                 sps_present_o
);
  import nalps_pkg::*;

  localparam int unsigned WideBits = (PositionBits > OffsetBits) ? PositionBits : OffsetBits;
  localparam logic [PositionBits-1:0] PosMax = '1;

  typedef enum logic [1:0] {
    PhSeek,
    PhHeader,
    PhParam,
    PhDone
  } phase_e;

  logic                    s1_valid_q;
  logic [ByteBits-1:0]     s1_byte_q;
  logic                    s1_last_q;
  logic                    s1_fire;
  logic                    out_free;

  logic [CodecBits-1:0]    codec_q;
  phase_e                  phase_q, phase_d;
  logic [1:0]              zero_run_q, zero_run_d;
  logic [PositionBits-1:0] pos_q, pos_d;
  logic [PositionBits-1:0] run_end_q, run_end_d;
  logic                    sps_q, sps_d;

  logic                    out_valid_q, out_valid_d;
  logic [OffsetBits-1:0]   out_offset_q, out_offset_d;
  logic                    out_sps_q, out_sps_d;

  logic                    hdr_param;
  logic                    hdr_sps;
  logic                    hdr_unknown;
  logic [PositionBits-1:0] back;
  logic [PositionBits-1:0] sc_offset;
  logic [PositionBits-1:0] result_pos;
  logic [WideBits-1:0]     result_wide;

  assign out_free   = !out_valid_q || out_ready_i;
  assign s1_fire    = s1_valid_q && (!s1_last_q || out_free);
  assign in_ready_o = !s1_valid_q || s1_fire;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      s1_byte_q <= stream_byte_i;
      s1_last_q <= end_of_unit_i;
    end
  end

  // Header classification
  always_comb begin
    hdr_param   = 1'b0;
    hdr_sps     = 1'b0;
    hdr_unknown = 1'b0;
    case (codec_q)
      CodecH264: begin
        hdr_sps   = (s1_byte_q[4:0] == H264Sps);
        hdr_param = (s1_byte_q[4:0] == H264Sps) || (s1_byte_q[4:0] == H264Pps) ||
                    (s1_byte_q[4:0] == H264Aud);
      end
      CodecH265: begin
        hdr_sps   = (s1_byte_q[6:1] == H265Sps);
        hdr_param = (s1_byte_q[6:1] == H265Vps) || (s1_byte_q[6:1] == H265Sps) ||
                    (s1_byte_q[6:1] == H265Pps) || (s1_byte_q[6:1] == H265Aud);
      end
      default: begin
        hdr_unknown = 1'b1;
      end
    endcase
  end

  // Start code offset: position of its first zero byte
  assign back      = (zero_run_q == ZeroRunMax) ? PositionBits'(3) : PositionBits'(2);
  assign sc_offset = (pos_q >= back) ? (pos_q - back) : '0;

  // Scan state update
  always_comb begin
    phase_d    = phase_q;
    zero_run_d = zero_run_q;
    run_end_d  = run_end_q;
    sps_d      = sps_q;

    unique case (phase_q)
      PhHeader: begin
        if (hdr_unknown) begin
          run_end_d = '0;
          phase_d   = PhDone;
        end else if (hdr_param) begin
          if (hdr_sps) begin
            sps_d = 1'b1;
          end
          phase_d = PhParam;
        end else begin
          phase_d = PhDone;
        end
        zero_run_d = (s1_byte_q == '0) ? 2'd1 : 2'd0;
      end
      PhSeek, PhParam: begin
        if (s1_byte_q == '0) begin
          if (zero_run_q != ZeroRunMax) begin
            zero_run_d = zero_run_q + 2'd1;
          end
        end else begin
          if ((s1_byte_q == ByteBits'(1)) && (zero_run_q >= 2'd2)) begin
            if (phase_q == PhParam) begin
              run_end_d = sc_offset;
            end
            phase_d = PhHeader;
          end
          zero_run_d = 2'd0;
        end
      end
      PhDone: begin
      end
      default: begin
      end
    endcase

    pos_d = (pos_q != PosMax) ? (pos_q + 1'b1) : pos_q;
  end

  // Result at the final byte
  always_comb begin
    if (phase_d == PhParam) begin
      result_pos = (pos_q != PosMax) ? (pos_q + 1'b1) : PosMax;
    end else begin
      result_pos = run_end_d;
    end
    result_wide  = WideBits'(result_pos);
    out_offset_d = result_wide[OffsetBits-1:0];
    out_sps_d    = sps_d;
    out_valid_d  = out_valid_q && !out_ready_i;
    if (s1_fire && s1_last_q) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      codec_q      <= CodecH264;
      phase_q      <= PhSeek;
      zero_run_q   <= 2'd0;
      pos_q        <= '0;
      run_end_q    <= '0;
      sps_q        <= 1'b0;
      out_valid_q  <= 1'b0;
      out_offset_q <= '0;
      out_sps_q    <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        codec_q <= cfg_wdata_i;
      end
      out_valid_q <= out_valid_d;
      if (s1_fire) begin
        if (s1_last_q) begin
          phase_q      <= PhSeek;
          zero_run_q   <= 2'd0;
          pos_q        <= '0;
          run_end_q    <= '0;
          sps_q        <= 1'b0;
          out_offset_q <= out_offset_d;
          out_sps_q    <= out_sps_d;
        end else begin
          phase_q    <= phase_d;
          zero_run_q <= zero_run_d;
          pos_q      <= pos_d;
          run_end_q  <= run_end_d;
          sps_q      <= sps_d;
        end
      end
    end
  end

  assign out_valid_o      = out_valid_q;
  assign run_end_offset_o = out_offset_q;
  assign sps_present_o    = out_sps_q;

  // A new result only follows a final byte leaving the input register
  `ASSERT_CLK(a_result_from_last, $rose(out_valid_q) |-> $past(s1_valid_q && s1_last_q), clk_i, rst_ni)
  // Unit state is cleared after the final byte
  `ASSERT_CLK(a_clear_after_last, (s1_fire && s1_last_q) |=> (pos_q == '0 && phase_q == PhSeek), clk_i, rst_ni)
  // Zero counter restarts at every start code
  `ASSERT_NEVER(a_header_zero_run, (phase_q == PhHeader) && (zero_run_q != 2'd0), clk_i, rst_ni)

endmodule

[tb/tb_nal_parameter_set_run_finder_unit.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Parameter-set run finder testbench
// Streams Annex-B access units into the block byte by byte, predicts the end
// of the leading parameter-set run and the SPS flag for each unit, and checks
// every result in order. Covers H.264, H.265 and unknown codec settings,
// random idling on both channels, a long output stall and a mid-unit codec
// change.
// ---------------------------------------------------------------------------
module tb_nal_parameter_set_run_finder_unit;
  import nalps_pkg::*;

  localparam int unsigned PosBits     = PositionBitsDflt;
  localparam logic [PosBits-1:0] PosMax = '1;
  localparam int unsigned DrainCycles = 8;
  localparam int unsigned LongStall   = 300;
  localparam logic [CodecBits-1:0] CodecOther = 2'd2;

  typedef enum logic [1:0] {
    SeekStart,
    ExpectHeader,
    InParamSet,
    ScanDone
  } scan_state_e;

  typedef struct packed {
    logic [ByteBits-1:0] data;
    logic                last;
  } stream_item_t;

  typedef struct packed {
    logic [OffsetBits-1:0] offset;
    logic                  sps;
  } run_result_t;

  typedef logic [ByteBits-1:0] byte_q_t[$];

  logic                  clk_i         = 1'b0;
  logic                  rst_ni        = 1'b0;
  logic                  cfg_we_i      = 1'b0;
  logic [CodecBits-1:0]  cfg_wdata_i   = '0;
  logic                  in_valid_i    = 1'b0;
  logic                  in_ready_o;
  logic [ByteBits-1:0]   stream_byte_i = '0;
  logic                  end_of_unit_i = 1'b0;
  logic                  out_valid_o;
  logic                  out_ready_i   = 1'b0;
  logic [OffsetBits-1:0] run_end_offset_o;
  logic                  sps_present_o;

  nal_parameter_set_run_finder_unit i_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .stream_byte_i    (stream_byte_i),
    .end_of_unit_i    (end_of_unit_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .run_end_offset_o (run_end_offset_o),
    .sps_present_o    (sps_present_o)
  );

  stream_item_t byte_feed[$];
  run_result_t  expected_runs[$];

  // predictor state
  logic [CodecBits-1:0] codec_sel  = CodecH264;
  scan_state_e          scan_state = SeekStart;
  logic [1:0]           zero_count = '0;
  logic [PosBits-1:0]   byte_pos   = '0;
  logic [PosBits-1:0]   run_end    = '0;
  logic                 sps_hit    = 1'b0;

  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned stall_req     = 0;
  int unsigned stall_ack     = 0;
  int unsigned hold_left     = 0;
  int unsigned mismatches    = 0;
  int unsigned bytes_accepted  = 0;
  int unsigned results_checked = 0;
  int unsigned codec_writes    = 0;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic void advance_scan(input logic [ByteBits-1:0] b, input logic last);
    logic [PosBits-1:0] pos;
    logic [PosBits-1:0] back;
    logic [PosBits-1:0] sc_off;
    logic [4:0]         t264;
    logic [5:0]         t265;
    logic               is_param;
    logic               is_sps;
    run_result_t        res;
    pos      = byte_pos;
    t264     = b[4:0];
    t265     = b[6:1];
    is_param = 1'b0;
    is_sps   = 1'b0;
    case (scan_state)
      ExpectHeader: begin
        if (codec_sel == CodecH264) begin
          is_sps   = (t264 == H264Sps);
          is_param = is_sps || (t264 == H264Pps) || (t264 == H264Aud);
        end else if (codec_sel == CodecH265) begin
          is_sps   = (t265 == H265Sps);
          is_param = is_sps || (t265 == H265Vps) || (t265 == H265Pps) || (t265 == H265Aud);
        end
        if (is_param) begin
          sps_hit    = sps_hit | is_sps;
          scan_state = InParamSet;
        end else begin
          if (codec_sel != CodecH264 && codec_sel != CodecH265) run_end = '0;
          scan_state = ScanDone;
        end
        zero_count = (b == 8'h00) ? 2'd1 : 2'd0;
      end
      SeekStart, InParamSet: begin
        if (b == 8'h00) begin
          if (zero_count != ZeroRunMax) zero_count = zero_count + 2'd1;
        end else begin
          if (b == 8'h01 && zero_count >= 2'd2) begin
            back   = (zero_count == ZeroRunMax) ? PosBits'(3) : PosBits'(2);
            sc_off = (pos >= back) ? pos - back : '0;
            if (scan_state == InParamSet) run_end = sc_off;
            scan_state = ExpectHeader;
          end
          zero_count = '0;
        end
      end
      default: ;
    endcase
    if (byte_pos != PosMax) byte_pos = byte_pos + 1'b1;
    if (last) begin
      if (scan_state == InParamSet) begin
        res.offset = OffsetBits'((pos != PosMax) ? pos + 1'b1 : PosMax);
      end else begin
        res.offset = OffsetBits'(run_end);
      end
      res.sps = sps_hit;
      expected_runs.push_back(res);
      scan_state = SeekStart;
      zero_count = '0;
      byte_pos   = '0;
      run_end    = '0;
      sps_hit    = 1'b0;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : drive_bytes
    stream_item_t nxt;
    if (!rst_ni) begin
      in_valid_i    <= 1'b0;
      stream_byte_i <= '0;
      end_of_unit_i <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        advance_scan(stream_byte_i, end_of_unit_i);
        bytes_accepted++;
      end
      if (!in_valid_i || in_ready_o) begin
        if (byte_feed.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          nxt = byte_feed.pop_front();
          in_valid_i    <= 1'b1;
          stream_byte_i <= nxt.data;
          end_of_unit_i <= nxt.last;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin : check_runs
    run_result_t want;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (expected_runs.size() == 0) begin
          $error("unexpected result: run_end_offset %0d sps_present %0b",
                 run_end_offset_o, sps_present_o);
          mismatches++;
        end else begin
          want = expected_runs.pop_front();
          results_checked++;
          if (run_end_offset_o !== want.offset) begin
            $error("run_end_offset mismatch: expected %0d, actual %0d",
                   want.offset, run_end_offset_o);
            mismatches++;
          end
          if (sps_present_o !== want.sps) begin
            $error("sps_present mismatch: expected %0b, actual %0b",
                   want.sps, sps_present_o);
            mismatches++;
          end
        end
      end
      if (stall_ack != stall_req) begin
        stall_ack = stall_req;
        hold_left = LongStall;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  task automatic queue_bytes(input byte_q_t bytes, input bit closes_unit);
    stream_item_t it;
    foreach (bytes[i]) begin
      it.data = bytes[i];
      it.last = closes_unit && (i == bytes.size() - 1);
      byte_feed.push_back(it);
    end
  endtask

  // waits until the block has nothing left in flight
  task automatic drain();
    while (byte_feed.size() != 0 || in_valid_i || expected_runs.size() != 0) begin
      @(negedge clk_i);
    end
    repeat (DrainCycles) @(negedge clk_i);
  endtask

  task automatic set_codec(input logic [CodecBits-1:0] kind);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= kind;
    codec_sel = kind;
    codec_writes++;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
  endtask

  function automatic logic [ByteBits-1:0] header_byte(input logic [CodecBits-1:0] kind,
                                                      input bit want_param);
    logic [4:0] t5;
    logic [5:0] t6;
    if (kind == CodecH264) begin
      if (want_param) begin
        t5 = H264Sps + 5'($urandom_range(0, 2));
      end else begin
        t5 = 5'($urandom_range(0, 28));
        if (t5 >= H264Sps) t5 = t5 + 5'd3;
      end
      return {3'($urandom_range(0, 7)), t5};
    end
    if (kind == CodecH265) begin
      if (want_param) begin
        t6 = H265Vps + 6'($urandom_range(0, 3));
      end else begin
        t6 = 6'($urandom_range(0, 59));
        if (t6 >= H265Vps) t6 = t6 + 6'd4;
      end
      return {1'($urandom_range(0, 1)), t6, 1'($urandom_range(0, 1))};
    end
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic logic [ByteBits-1:0] payload_byte();
    if ($urandom_range(0, 4) == 0) return 8'h00;
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic byte_q_t make_unit(input logic [CodecBits-1:0] kind);
    byte_q_t u;
    int      n_nal;
    int      plen;
    u = {};
    // noise: zeros, ones and random bytes with no intended structure
    if ($urandom_range(0, 99) < 20) begin
      plen = $urandom_range(1, 12);
      repeat (plen) begin
        case ($urandom_range(0, 3))
          0, 1:    u.push_back(8'h00);
          2:       u.push_back(8'h01);
          default: u.push_back(8'($urandom_range(0, 255)));
        endcase
      end
      return u;
    end
    n_nal = $urandom_range(1, 4);
    for (int i = 0; i < n_nal; i++) begin
      if ($urandom_range(0, 3) == 0) u.push_back(8'h00);
      u.push_back(8'h00);
      u.push_back(8'h00);
      u.push_back(8'h01);
      if (i == n_nal - 1 && $urandom_range(0, 9) == 0) return u;
      u.push_back(header_byte(kind, $urandom_range(0, 99) < 75));
      plen = $urandom_range(0, 6);
      repeat (plen) u.push_back(payload_byte());
    end
    return u;
  endfunction

  initial begin : stimulus
    logic [CodecBits-1:0] codec_order [3];
    int unsigned          budget;
    int unsigned          queued;
    byte_q_t              unit;
    codec_order = '{CodecH264, CodecH265, CodecOther};
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed units, H.264 after reset
    queue_bytes('{8'hFF}, 1);
    queue_bytes('{8'h00, 8'h00, 8'h01, 8'h65}, 1);
    queue_bytes('{8'h00, 8'h00, 8'h01, 8'h67, 8'h00, 8'h00, 8'h01}, 1);
    queue_bytes('{8'h00, 8'h00, 8'h00, 8'h01, 8'h68}, 1);
    drain();
    // VPS under H.265, then the codec changes inside the unit
    set_codec(CodecH265);
    queue_bytes('{8'h00, 8'h00, 8'h01, 8'h40}, 0);
    drain();
    set_codec(CodecH264);
    queue_bytes('{8'h00, 8'h00, 8'h01, 8'h42}, 1);
    drain();
    set_codec(CodecOther);
    queue_bytes('{8'h00, 8'h00, 8'h01, 8'h67}, 1);
    drain();

    for (int m = 0; m < 3; m++) begin
      for (int c = 0; c < 3; c++) begin
        drain();
        set_codec(codec_order[(c + m) % 3]);
        case (m)
          0: begin
            send_idle_pct = 22;
            recv_idle_pct = 45;
          end
          1: begin
            send_idle_pct = 45;
            recv_idle_pct = 22;
          end
          default: begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
          end
        endcase
        if (m == 0 && c == 0) stall_req++;
        budget = (codec_sel == CodecOther) ? 90 : 170;
        queued = 0;
        while (queued < budget) begin
          unit = make_unit(codec_sel);
          queue_bytes(unit, 1);
          queued += unit.size();
        end
      end
    end

    drain();
    $display("Checked %0d access units from %0d bytes across %0d codec writes,",
             results_checked, bytes_accepted, codec_writes);
    $display("with H.264, H.265 and unknown codecs, mixed idling and a long output stall.");
    if (mismatches == 0) begin
      $display("nal_parameter_set_run_finder_unit verification clean");
    end else begin
      $display("nal_parameter_set_run_finder_unit verification failed");
    end
    $finish;
  end

  initial begin : watchdog
    #2000000;
    $display("nal_parameter_set_run_finder_unit verification failed");
    $finish;
  end

endmodule
